[hdl/strict_priority_multi_fifo_core_assert.svh]
// assertion macros for the strict priority multi fifo core
`ifndef STRICT_PRIORITY_MULTI_FIFO_CORE_ASSERT_SVH
`define STRICT_PRIORITY_MULTI_FIFO_CORE_ASSERT_SVH

// same-cycle implication on clk, disabled while arst_n is low
`define SPMF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spmf assertion failed");

// next-cycle implication on clk, disabled while arst_n is low
`define SPMF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spmf assertion failed");

`endif

[hdl/spmf_pkg.sv]
// package with types, codes and defaults of the strict priority multi fifo core
package spmf_pkg;

	localparam int LEVELS_DEF = 5;
	localparam int DEPTH_DEF  = 16;

	typedef enum logic {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [15:0] order_number;
		logic [2:0]  urgency;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [15:0] popped_number;
		logic [2:0]  popped_urgency;
		logic        rejected;
		logic        all_empty;
	} out_item_t;

	typedef struct packed {
		logic       found;
		logic [2:0] popped_urgency;
		logic       rejected;
		logic       all_empty;
	} decision_t;

endpackage

[hdl/spmf_stream_if.sv]
// valid/ready stream interface with a typed payload
interface spmf_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (
		output valid,
		output payload,
		input  ready
	);

	modport sink (
		input  valid,
		input  payload,
		output ready
	);
endinterface

[hdl/spmf_ram.sv]
// generic single port ram with registered read
module spmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 80
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                          wdata,
	output logic [WIDTH-1:0]                          rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rd_data <= mem_q[addr];
		end
	end
endmodule

[hdl/spmf_ctrl.sv]
// queue pointers, occupancy counters and strict priority selection
module spmf_ctrl #(
	parameter int LEVELS = spmf_pkg::LEVELS_DEF,
	parameter int DEPTH  = spmf_pkg::DEPTH_DEF,
	localparam int AW = (LEVELS * DEPTH > 1) ? $clog2(LEVELS * DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  spmf_pkg::in_item_t  item,
	output spmf_pkg::decision_t dec,
	output logic                mem_we,
	output logic                mem_re,
	output logic [AW-1:0]       mem_addr
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [PW-1:0] head_q  [LEVELS];
	logic [PW-1:0] tail_q  [LEVELS];
	logic [CW-1:0] count_q [LEVELS];

	logic [LEVELS-1:0] nonempty;
	logic [LEVELS-1:0] nonempty_after;
	logic [LEVELS-1:0] push_oh;
	logic [LEVELS-1:0] pop_oh;
	logic              is_push;
	logic              is_pop;
	logic              taken;

	assign is_push = (item.func == spmf_pkg::FUNC_PUSH);
	assign is_pop  = (item.func == spmf_pkg::FUNC_POP);

	always_comb begin
		taken              = 1'b0;
		mem_addr           = '0;
		dec.popped_urgency = '0;
		for (int l = 0; l < LEVELS; l++) begin
			nonempty[l] = (count_q[l] != '0);
			push_oh[l]  = is_push && (32'(item.urgency) == 32'(l + 1))
				&& (count_q[l] != CW'(DEPTH));
			pop_oh[l]   = is_pop && nonempty[l] && !taken;
			taken       = taken | nonempty[l];
			nonempty_after[l] = push_oh[l]
				| (nonempty[l] & !(pop_oh[l] && (count_q[l] == CW'(1))));
			if (push_oh[l]) begin
				mem_addr = mem_addr | (AW'(l * DEPTH) + AW'(tail_q[l]));
			end
			if (pop_oh[l]) begin
				mem_addr = mem_addr | (AW'(l * DEPTH) + AW'(head_q[l]));
				dec.popped_urgency = dec.popped_urgency | 3'(l + 1);
			end
		end
		dec.found     = |pop_oh;
		dec.rejected  = is_push && !(|push_oh);
		dec.all_empty = ~|nonempty_after;
	end

	assign mem_we = en && (|push_oh);
	assign mem_re = en && (|pop_oh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else if (en) begin
			for (int l = 0; l < LEVELS; l++) begin
				if (push_oh[l]) begin
					tail_q[l]  <= (tail_q[l] == PW'(DEPTH - 1)) ? '0 : tail_q[l] + 1'b1;
					count_q[l] <= count_q[l] + 1'b1;
				end
				if (pop_oh[l]) begin
					head_q[l]  <= (head_q[l] == PW'(DEPTH - 1)) ? '0 : head_q[l] + 1'b1;
					count_q[l] <= count_q[l] - 1'b1;
				end
			end
		end
	end
endmodule

[hdl/strict_priority_multi_fifo_core.sv]
// top level of the strict priority multi fifo core
// LEVELS fifo queues of DEPTH order numbers each, level 1 most urgent. Every request
// (push or pop) gives exactly one response. One request is taken per clock cycle unless
// rsp stalls; it is held in the input register, decided there against the queue counters,
// and its response is registered in the output stage, its order number read from the
// single port order store whose one access per request sets that rate. The store needs
// no clearing pass after reset. Backpressure on rsp stalls both stages.
`include "strict_priority_multi_fifo_core_assert.svh"

module strict_priority_multi_fifo_core #(
	parameter int LEVELS = spmf_pkg::LEVELS_DEF,
	parameter int DEPTH  = spmf_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	spmf_stream_if.sink   req,
	spmf_stream_if.source rsp
);
	localparam int AW = (LEVELS * DEPTH > 1) ? $clog2(LEVELS * DEPTH) : 1;

	spmf_pkg::in_item_t  item_s1;
	logic                valid_s1;
	spmf_pkg::decision_t dec;
	spmf_pkg::decision_t dec_s2;
	logic                valid_s2;
	logic                advance;
	logic                fire_s1;
	logic                mem_we;
	logic                mem_re;
	logic [AW-1:0]       mem_addr;
	logic [15:0]         rd_data;

	assign advance   = !valid_s2 || rsp.ready;
	assign fire_s1   = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.payload;
		end
		if (fire_s1) begin
			dec_s2 <= dec;
		end
	end

	spmf_ctrl #(
		.LEVELS (LEVELS),
		.DEPTH  (DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (fire_s1),
		.item     (item_s1),
		.dec      (dec),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr)
	);

	spmf_ram #(
		.WIDTH (16),
		.DEPTH (LEVELS * DEPTH)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.re      (mem_re),
		.addr    (mem_addr),
		.wdata   (item_s1.order_number),
		.rd_data (rd_data)
	);

	assign rsp.valid                  = valid_s2;
	assign rsp.payload.found          = dec_s2.found;
	assign rsp.payload.popped_number  = dec_s2.found ? rd_data : 16'd0;
	assign rsp.payload.popped_urgency = dec_s2.popped_urgency;
	assign rsp.payload.rejected       = dec_s2.rejected;
	assign rsp.payload.all_empty      = dec_s2.all_empty;

	// a stalled request stays in the input register
	`SPMF_ASSERT_NXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(item_s1))
	// a stalled popped order keeps its store read data
	`SPMF_ASSERT_NXT(a_rd_hold, valid_s2 && dec_s2.found && !rsp.ready, $stable(rd_data))
	// the store is never read and written by the same request
	`SPMF_ASSERT_IMP(a_one_access, fire_s1, !(mem_we && mem_re))
	// a refused push reports no popped order
	`SPMF_ASSERT_IMP(a_rej_clean, valid_s2 && dec_s2.rejected,
		!dec_s2.found && (dec_s2.popped_urgency == 3'd0))
endmodule
